// ===== rtl/core/trimmed_mean_adc_averager_core_assert.svh =====
// Assertion macros shared by the trimmed-mean averager RTL.
`ifndef TRIMMED_MEAN_ADC_AVERAGER_CORE_ASSERT_SVH
`define TRIMMED_MEAN_ADC_AVERAGER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define TMAA_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define TMAA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define TMAA_ASSERT_IMPLY(label, ante, cons)
`define TMAA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/tmaa_pkg.sv =====
// Widths, register indexes and divider constants of the trimmed-mean averager.
package tmaa_pkg;

   // Field and accumulator widths.
   localparam int SAMPLE_W = 10;
   localparam int COUNT_W  = 8;
   localparam int SUM_W    = SAMPLE_W + COUNT_W;
   localparam int TDIV_W   = 16;
   localparam int SCALED_W = 18;
   localparam int TEMP_FRAC_W = 8;
   localparam int VOLT_FRAC_W = 16;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASURE_MODE  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_DIVISOR  = 2'd3;

   // Configuration reset values.
   localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 8'd8;
   localparam logic [TDIV_W-1:0]  TEMP_DIVISOR_RESET = 16'd256;

   // Voltage divisor and saturation limits.
   localparam logic [TDIV_W-1:0]   VOLT_DIVISOR = 16'd400;
   localparam logic [SCALED_W-1:0] TEMP_SAT     = 18'd65535;

   // Divider iteration counts: the mean has SAMPLE_W quotient bits and the
   // scaled value SCALED_W quotient bits.
   localparam int ITER_W = 5;
   localparam logic [ITER_W-1:0] DIV1_STEPS = 5'd10;
   localparam logic [ITER_W-1:0] DIV2_STEPS = 5'd18;

endpackage

// ===== rtl/core/trimmed_mean_adc_averager_core.sv =====
// Trimmed-mean averager for converter samples with a bit-serial divider.
//
// Usage:
//   Samples enter on the req_ channel (valid/ready). Each sample is folded
//   into a running sum, minimum, maximum and count, and the
//   block is ready again in the next cycle. The sample that completes a
//   block of sample_count samples starts the result computation, during
//   which req_ready is low:
//     a trim step (drop min and max when filtering),
//     the mean, one quotient bit per cycle,
//     the scaled value, one quotient bit per cycle,
//     a last step that saturates temperature results and hands the item to
//     the output register once it is free.
//   The restoring divider produces both the mean and the scaled value.
//   The output register lets new samples be accepted while a result waits.
//   If the receiver stalls and a second result is ready, the block holds it
//   and keeps req_ready low until the output register is taken.
//   Configuration is to be written on the csr_ port only while the block is
//   idle; the block does not enforce this. Synchronous reset clears the
//   accumulators and valid flag and returns configuration to its defaults.
`include "trimmed_mean_adc_averager_core_assert.svh"
module trimmed_mean_adc_averager_core (
   input  logic clock,
   input  logic reset,
   // Sample input channel.
   input  logic req_valid,
   output logic req_ready,
   input  logic [tmaa_pkg::SAMPLE_W-1:0] req_sample,
   // Result output channel.
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [tmaa_pkg::SAMPLE_W-1:0] rsp_mean_code,
   output logic [tmaa_pkg::SCALED_W-1:0] rsp_scaled_value,
   // Configuration write port.
   input  logic csr_write,
   input  logic [tmaa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tmaa_pkg::TDIV_W-1:0] csr_wdata
);
   import tmaa_pkg::*;

   // State codes of the sequencer.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TRIM = 3'd1;
   localparam logic [2:0] ST_DIV1 = 3'd2;
   localparam logic [2:0] ST_DIV2 = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;

   // Configuration registers.
   logic [COUNT_W-1:0] sample_count_ff;
   logic               filter_enable_ff;
   logic               measure_mode_ff;
   logic [TDIV_W-1:0]  temp_divisor_ff;

   // Accumulators.
   logic [COUNT_W-1:0]  taken_count_ff, taken_count_in;
   logic [SUM_W-1:0]    running_sum_ff, running_sum_in;
   logic [SAMPLE_W-1:0] running_min_ff, running_min_in;
   logic [SAMPLE_W-1:0] running_max_ff, running_max_in;

   // Divider registers: partial remainder, numerator/quotient shift line,
   // divisor and step counter.
   logic [TDIV_W-1:0]   rem_ff, rem_in;
   logic [SCALED_W-1:0] qn_ff, qn_in;
   logic [TDIV_W-1:0]   div_ff, div_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   logic [SAMPLE_W-1:0] mean_ff, mean_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_mean_code_ff, rsp_mean_code_in;
   logic [SCALED_W-1:0] rsp_scaled_value_ff, rsp_scaled_value_in;

   logic                accept;
   logic [COUNT_W-1:0]  count_next;
   logic [COUNT_W-1:0]  count_target;
   logic                use_trim;
   logic [SUM_W-1:0]    trim_num;
   logic [COUNT_W-1:0]  trim_div;
   logic [TDIV_W:0]     trial;
   logic [TDIV_W+1:0]   trial_diff;
   logic                take;
   logic [TDIV_W-1:0]   rem_step;
   logic [SCALED_W-1:0] qn_step;
   logic [SAMPLE_W-1:0] mean_done;
   logic [SCALED_W-1:0] scaled_done;
   logic                out_free;

   assign req_ready        = (state_ff == ST_IDLE);
   assign accept           = req_valid && req_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_code    = rsp_mean_code_ff;
   assign rsp_scaled_value = rsp_scaled_value_ff;
   assign out_free         = !rsp_valid_ff || rsp_ready;

   // Block length: a count of zero means one sample.
   assign count_next   = taken_count_ff + COUNT_W'(1);
   assign count_target = (sample_count_ff == '0) ? COUNT_W'(1) : sample_count_ff;

   // Trimmed numerator and divisor, valid only with three or more samples.
   assign use_trim = filter_enable_ff && (taken_count_ff >= COUNT_W'(3));
   assign trim_num = running_sum_ff - SUM_W'(running_min_ff) - SUM_W'(running_max_ff);
   assign trim_div = taken_count_ff - COUNT_W'(2);

   // One restoring division step: shift in the next numerator bit, subtract
   // the divisor if it fits and shift the quotient bit into the line.
   assign trial      = {rem_ff, qn_ff[SCALED_W-1]};
   assign trial_diff = {1'b0, trial} - {2'b00, div_ff};
   assign take       = !trial_diff[TDIV_W+1];
   assign rem_step   = take ? trial_diff[TDIV_W-1:0] : trial[TDIV_W-1:0];
   assign qn_step    = {qn_ff[SCALED_W-2:0], take};
   assign mean_done  = qn_step[SAMPLE_W-1:0];

   // Temperature results saturate, and a zero divisor gives full scale.
   always_comb begin
      if (measure_mode_ff) begin
         scaled_done = qn_ff;
      end else if ((div_ff == '0) || (qn_ff > TEMP_SAT)) begin
         scaled_done = TEMP_SAT;
      end else begin
         scaled_done = qn_ff;
      end
   end

   // Sequencer, accumulators and divider datapath.
   always_comb begin
      state_in            = state_ff;
      taken_count_in      = taken_count_ff;
      running_sum_in      = running_sum_ff;
      running_min_in      = running_min_ff;
      running_max_in      = running_max_ff;
      rem_in              = rem_ff;
      qn_in               = qn_ff;
      div_in              = div_ff;
      iter_in             = iter_ff;
      mean_in             = mean_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_mean_code_in    = rsp_mean_code_ff;
      rsp_scaled_value_in = rsp_scaled_value_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               taken_count_in = count_next;
               running_sum_in = running_sum_ff + SUM_W'(req_sample);
               if (req_sample < running_min_ff) begin
                  running_min_in = req_sample;
               end
               if (req_sample > running_max_ff) begin
                  running_max_in = req_sample;
               end
               if (count_next >= count_target) begin
                  state_in = ST_TRIM;
               end
            end
         end
         ST_TRIM: begin
            // The mean fits in SAMPLE_W bits, so the upper numerator bits
            // start out as the partial remainder.
            if (use_trim) begin
               rem_in = TDIV_W'(trim_num[SUM_W-1:SAMPLE_W]);
               qn_in  = {trim_num[SAMPLE_W-1:0], {(SCALED_W-SAMPLE_W){1'b0}}};
               div_in = TDIV_W'(trim_div);
            end else begin
               rem_in = TDIV_W'(running_sum_ff[SUM_W-1:SAMPLE_W]);
               qn_in  = {running_sum_ff[SAMPLE_W-1:0], {(SCALED_W-SAMPLE_W){1'b0}}};
               div_in = TDIV_W'(taken_count_ff);
            end
            iter_in        = DIV1_STEPS;
            taken_count_in = '0;
            running_sum_in = '0;
            running_min_in = '1;
            running_max_in = '0;
            state_in       = ST_DIV1;
         end
         ST_DIV1: begin
            rem_in  = rem_step;
            qn_in   = qn_step;
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == ITER_W'(1)) begin
               // Load the scaling division from the finished mean.
               mean_in = mean_done;
               iter_in = DIV2_STEPS;
               if (measure_mode_ff) begin
                  rem_in = TDIV_W'(mean_done[SAMPLE_W-1:2]);
                  qn_in  = {mean_done[1:0], {VOLT_FRAC_W{1'b0}}};
                  div_in = VOLT_DIVISOR;
               end else begin
                  rem_in = '0;
                  qn_in  = {mean_done, {TEMP_FRAC_W{1'b0}}};
                  div_in = temp_divisor_ff;
               end
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            rem_in  = rem_step;
            qn_in   = qn_step;
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == ITER_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_mean_code_in    = mean_ff;
               rsp_scaled_value_in = scaled_done;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers and accumulators.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         taken_count_ff <= '0;
         running_sum_ff <= '0;
         running_min_ff <= '1;
         running_max_ff <= '0;
         iter_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         taken_count_ff <= taken_count_in;
         running_sum_ff <= running_sum_in;
         running_min_ff <= running_min_in;
         running_max_ff <= running_max_in;
         iter_ff        <= iter_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Divider and output payload registers.
   always_ff @(posedge clock) begin
      rem_ff              <= rem_in;
      qn_ff               <= qn_in;
      div_ff              <= div_in;
      mean_ff             <= mean_in;
      rsp_mean_code_ff    <= rsp_mean_code_in;
      rsp_scaled_value_ff <= rsp_scaled_value_in;
   end

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff  <= SAMPLE_COUNT_RESET;
         filter_enable_ff <= 1'b1;
         measure_mode_ff  <= 1'b0;
         temp_divisor_ff  <= TEMP_DIVISOR_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SAMPLE_COUNT:  sample_count_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_FILTER_ENABLE: filter_enable_ff <= csr_wdata[0];
            CSR_MEASURE_MODE:  measure_mode_ff  <= csr_wdata[0];
            CSR_TEMP_DIVISOR:  temp_divisor_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The partial remainder always stays below a nonzero divisor.
   `TMAA_ASSERT_IMPLY(a_rem_below_div, ((state_ff == ST_DIV1) || (state_ff == ST_DIV2)) && (div_ff != '0), rem_ff < div_ff)
   // The step counter never runs out inside a division.
   `TMAA_ASSERT_IMPLY(a_iter_live, (state_ff == ST_DIV1) || (state_ff == ST_DIV2), iter_ff != '0)
   // The accumulators are empty once a block has been handed to the divider.
   `TMAA_ASSERT_NEXT(a_acc_cleared, state_ff == ST_TRIM, (taken_count_ff == '0) && (running_sum_ff == '0))
   // Any taken sample leaves the minimum at or below the maximum.
   `TMAA_ASSERT_IMPLY(a_min_le_max, taken_count_ff != '0, running_min_ff <= running_max_ff)

endmodule

// ===== tb/tb_trimmed_mean_adc_averager_core.sv =====
// Self-checking testbench of the trimmed-mean averager core.
`timescale 1ns / 1ps

module tb_trimmed_mean_adc_averager_core;
   import tmaa_pkg::*;

   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 1030;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
   localparam logic [SCALED_W-1:0] SCALED_MAX = '1;

   // One averaged result: raw mean code and its scaled value.
   typedef struct packed {
      logic [SAMPLE_W-1:0] mean_code;
      logic [SCALED_W-1:0] scaled_value;
   } mean_result_type;

   // Rows of the directed stimulus table.
   typedef enum logic {ROW_CSR, ROW_SAMPLE} row_kind_type;
   typedef struct packed {
      row_kind_type kind;
      logic [CSR_INDEX_W-1:0] idx;
      logic [TDIV_W-1:0] data;
      logic typed;
      logic [SAMPLE_W-1:0] exp_mean;
      logic [SCALED_W-1:0] exp_scaled;
   } plan_row_type;

   localparam int NROWS = 35;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [SAMPLE_W-1:0] rsp_mean_code;
   logic [SCALED_W-1:0] rsp_scaled_value;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [TDIV_W-1:0] csr_wdata = '0;

   int send_idle_pct = 16;
   int recv_idle_pct = 60;
   int mismatch_count = 0;
   int cycle_count = 0;

   // Predictor copy of the configuration and the accumulators.
   logic [COUNT_W-1:0] avg_count = SAMPLE_COUNT_RESET;
   logic avg_filter = 1'b1;
   logic avg_mode = 1'b0;
   logic [TDIV_W-1:0] avg_tdiv = TEMP_DIVISOR_RESET;
   int acc_taken = 0;
   logic [SUM_W-1:0] acc_sum = '0;
   logic [SAMPLE_W-1:0] acc_min = '1;
   logic [SAMPLE_W-1:0] acc_max = '0;

   // Averages still owed by the block, oldest first.
   mean_result_type pending_means[$];
   mean_result_type head_mean;

   // Directed items: extremes, both scalings, zero count and divisor,
   // saturation, trimming, short blocks and a count lowered mid-block.
   plan_row_type plan [NROWS] = '{
      '{ROW_CSR,    CSR_SAMPLE_COUNT,  16'd1,    1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd0,    1'b1, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd1023, 1'b1, 10'd1023, 18'd1023},
      '{ROW_CSR,    CSR_MEASURE_MODE,  16'd1,    1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd1023, 1'b1, 10'd1023, 18'd167608},
      '{ROW_SAMPLE, '0,                16'd0,    1'b1, 10'd0,    18'd0},
      '{ROW_CSR,    CSR_MEASURE_MODE,  16'd0,    1'b0, 10'd0,    18'd0},
      '{ROW_CSR,    CSR_TEMP_DIVISOR,  16'd0,    1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd5,    1'b1, 10'd5,    18'd65535},
      '{ROW_CSR,    CSR_TEMP_DIVISOR,  16'd1,    1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd1023, 1'b1, 10'd1023, 18'd65535},
      '{ROW_SAMPLE, '0,                16'd100,  1'b1, 10'd100,  18'd25600},
      '{ROW_CSR,    CSR_SAMPLE_COUNT,  16'd0,    1'b0, 10'd0,    18'd0},
      '{ROW_CSR,    CSR_TEMP_DIVISOR,  16'd65535, 1'b0, 10'd0,   18'd0},
      '{ROW_SAMPLE, '0,                16'd1023, 1'b1, 10'd1023, 18'd3},
      '{ROW_CSR,    CSR_SAMPLE_COUNT,  16'd3,    1'b0, 10'd0,    18'd0},
      '{ROW_CSR,    CSR_TEMP_DIVISOR,  16'd256,  1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd0,    1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd1023, 1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd500,  1'b1, 10'd500,  18'd500},
      '{ROW_CSR,    CSR_FILTER_ENABLE, 16'd0,    1'b0, 10'd0,    18'd0},
      '{ROW_CSR,    CSR_SAMPLE_COUNT,  16'd2,    1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd1023, 1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd1022, 1'b0, 10'd0,    18'd0},
      '{ROW_CSR,    CSR_FILTER_ENABLE, 16'd1,    1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd10,   1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd21,   1'b0, 10'd0,    18'd0},
      '{ROW_CSR,    CSR_SAMPLE_COUNT,  16'd8,    1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd700,  1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd3,    1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd1000, 1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd640,  1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd511,  1'b0, 10'd0,    18'd0},
      '{ROW_CSR,    CSR_SAMPLE_COUNT,  16'd3,    1'b0, 10'd0,    18'd0},
      '{ROW_SAMPLE, '0,                16'd512,  1'b0, 10'd0,    18'd0}
   };

   trimmed_mean_adc_averager_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_mean_code(rsp_mean_code),
      .rsp_scaled_value(rsp_scaled_value),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Run limit; a hung block ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver stalls at random, per phase.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic report_mismatch(input string what, input int expv, input int gotv);
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, expv, gotv);
      mismatch_count++;
   endtask

   // Fold one sample into the accumulators; returns 1 when a block completes.
   function automatic bit fold_sample(input logic [SAMPLE_W-1:0] smp,
                                      output mean_result_type res);
      int n;
      int mean;
      longint q;
      n = (avg_count == 0) ? 1 : int'(avg_count);
      res = '0;
      acc_sum = acc_sum + smp;
      if (smp < acc_min) acc_min = smp;
      if (smp > acc_max) acc_max = smp;
      acc_taken++;
      if (acc_taken < n) return 1'b0;
      // Trim the extremes only when at least three samples were taken.
      if (avg_filter && acc_taken >= 3) begin
         mean = (int'(acc_sum) - int'(acc_min) - int'(acc_max)) / (acc_taken - 2);
      end else begin
         mean = int'(acc_sum) / acc_taken;
      end
      res.mean_code = (mean > int'(SAMPLE_MAX)) ? SAMPLE_MAX : mean[SAMPLE_W-1:0];
      if (!avg_mode) begin
         if (avg_tdiv == 0) begin
            res.scaled_value = TEMP_SAT;
         end else begin
            q = (longint'(mean) << TEMP_FRAC_W) / avg_tdiv;
            res.scaled_value = (q > longint'(TEMP_SAT)) ? TEMP_SAT : q[SCALED_W-1:0];
         end
      end else begin
         q = (longint'(mean) << VOLT_FRAC_W) / VOLT_DIVISOR;
         res.scaled_value = (q > longint'(SCALED_MAX)) ? SCALED_MAX : q[SCALED_W-1:0];
      end
      acc_taken = 0;
      acc_sum = '0;
      acc_min = '1;
      acc_max = '0;
      return 1'b1;
   endfunction

   // Offer one sample and wait until the block takes it.
   task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input bit typed,
                              input mean_result_type typed_res);
      mean_result_type res;
      bit done;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= smp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      done = fold_sample(smp, res);
      if (typed) pending_means.push_back(typed_res);
      else if (done) pending_means.push_back(res);
      @(negedge clock);
   endtask

   // Hold the sender off until every owed average has come out.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_means.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [TDIV_W-1:0] data);
      case (idx)
         CSR_SAMPLE_COUNT:  avg_count = data[COUNT_W-1:0];
         CSR_FILTER_ENABLE: avg_filter = data[0];
         CSR_MEASURE_MODE:  avg_mode = data[0];
         CSR_TEMP_DIVISOR:  avg_tdiv = data;
         default: ;
      endcase
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Compare each result with the oldest owed average.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_means.size() == 0) begin
            report_mismatch("result with nothing owed, mean_code", -1, int'(rsp_mean_code));
         end else begin
            head_mean = pending_means.pop_front();
            if (rsp_mean_code !== head_mean.mean_code)
               report_mismatch("mean_code", int'(head_mean.mean_code), int'(rsp_mean_code));
            if (rsp_scaled_value !== head_mean.scaled_value)
               report_mismatch("scaled_value", int'(head_mean.scaled_value),
                               int'(rsp_scaled_value));
         end
      end
   end

   initial begin
      int row;
      int seg;
      int seg_len;
      int seg_style;
      int seg_base;
      int n_eff;
      int t;
      int random_sent;
      int drain_cycles;
      int pick;
      logic [COUNT_W-1:0] cnt8;
      logic fil;
      logic mode_bit;
      logic [TDIV_W-1:0] div16;
      logic [TDIV_W-1:0] wd;
      logic [SAMPLE_W-1:0] smp;
      mean_result_type typed_res;

      random_sent = 0;
      drain_cycles = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table.
      for (row = 0; row < NROWS; row++) begin
         if (plan[row].kind == ROW_CSR) begin
            settle_block();
            write_csr(plan[row].idx, plan[row].data);
         end else begin
            typed_res.mean_code = plan[row].exp_mean;
            typed_res.scaled_value = plan[row].exp_scaled;
            push_sample(plan[row].data[SAMPLE_W-1:0], plan[row].typed, typed_res);
         end
      end

      // Random segments, each under its own configuration.
      seg = 0;
      while (random_sent < RANDOM_ITEMS) begin
         settle_block();
         if (seg == 0) begin
            cnt8 = 8'd255;
            fil = 1'b1;
            mode_bit = 1'b1;
            div16 = 16'hFFFF;
         end else if (seg == 1) begin
            cnt8 = 8'd1;
            fil = 1'b0;
            mode_bit = 1'b0;
            div16 = 16'd1;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0) cnt8 = 8'd0;
            else if (pick <= 6) cnt8 = 8'($urandom_range(1, 8));
            else if (pick <= 8) cnt8 = 8'($urandom_range(9, 40));
            else cnt8 = 8'($urandom_range(41, 120));
            fil = 1'($urandom);
            mode_bit = 1'($urandom);
            pick = $urandom_range(0, 9);
            case (pick)
               5: div16 = 16'd0;
               6: div16 = 16'd1;
               7: div16 = 16'hFFFF;
               8: div16 = TEMP_DIVISOR_RESET;
               9: div16 = 16'($urandom_range(1, 16));
               default: div16 = 16'($urandom);
            endcase
         end
         // Bits above a narrow register's width are ignored by the block.
         wd = 16'($urandom);
         write_csr(CSR_SAMPLE_COUNT, {wd[15:8], cnt8});
         write_csr(CSR_FILTER_ENABLE, {wd[15:1], fil});
         write_csr(CSR_MEASURE_MODE, {wd[14:0], mode_bit});
         write_csr(CSR_TEMP_DIVISOR, div16);

         // Blocks (one if long, else two to six) plus a partial tail carried over.
         n_eff = (cnt8 == 0) ? 1 : int'(cnt8);
         seg_len = n_eff * ((n_eff > 40) ? 1 : $urandom_range(2, 6)) + $urandom_range(0, 3);
         seg_style = $urandom_range(0, 3);
         seg_base = $urandom_range(0, int'(SAMPLE_MAX));
         typed_res = '0;
         for (int k = 0; k < seg_len; k++) begin
            if (random_sent < RANDOM_ITEMS / 3) begin
               send_idle_pct = 16;
               recv_idle_pct = 60;
            end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
               send_idle_pct = 60;
               recv_idle_pct = 16;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            t = seg_base + $urandom_range(0, 30) - 15;
            if (t < 0) t = 0;
            if (t > int'(SAMPLE_MAX)) t = int'(SAMPLE_MAX);
            case (seg_style)
               0: smp = SAMPLE_W'($urandom_range(0, int'(SAMPLE_MAX)));
               1: smp = $urandom_range(0, 1) ? SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 2))
                                             : SAMPLE_W'($urandom_range(0, 2));
               2: smp = t[SAMPLE_W-1:0];
               default: begin
                  // Mostly a tight cluster with an occasional outlier to trim.
                  if ($urandom_range(0, 7) == 0)
                     smp = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
                  else
                     smp = t[SAMPLE_W-1:0];
               end
            endcase
            push_sample(smp, 1'b0, typed_res);
            random_sent++;
         end
         seg++;
      end

      // Drain the remaining averages, then let the block settle.
      req_valid <= 1'b0;
      while (pending_means.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_means.size() != 0)
         report_mismatch("averages never delivered, count", 0, pending_means.size());

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
